/* design/fsce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsce_pkg: shared definitions for the instruction executor
// Operation codes, reset constants and default sizes.
// ----------------------------------------------------------------------------
package fsce_pkg;

   localparam int unsigned DATA_W          = 32;
   localparam int unsigned REG_COUNT_DEF   = 16;
   localparam int unsigned DATA_WORDS_DEF  = 4096;

   localparam logic [DATA_W-1:0] RESET_PC  = 32'd4000;
   localparam logic [DATA_W-1:0] PC_STEP   = 32'd4;

   // operation codes of the mode field; unlisted codes act as no-op
   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_SUB   = 5'd1;
   localparam logic [4:0] OP_MUL   = 5'd2;
   localparam logic [4:0] OP_DIV   = 5'd3;
   localparam logic [4:0] OP_AND   = 5'd4;
   localparam logic [4:0] OP_OR    = 5'd5;
   localparam logic [4:0] OP_XOR   = 5'd6;
   localparam logic [4:0] OP_ADDL  = 5'd7;
   localparam logic [4:0] OP_SUBL  = 5'd8;
   localparam logic [4:0] OP_MOVC  = 5'd9;
   localparam logic [4:0] OP_LOAD  = 5'd10;
   localparam logic [4:0] OP_LDR   = 5'd11;
   localparam logic [4:0] OP_STORE = 5'd12;
   localparam logic [4:0] OP_STR   = 5'd13;
   localparam logic [4:0] OP_CMP   = 5'd14;
   localparam logic [4:0] OP_BZ    = 5'd15;
   localparam logic [4:0] OP_BNZ   = 5'd16;
   localparam logic [4:0] OP_HALT  = 5'd17;
   localparam logic [4:0] OP_NOP   = 5'd18;

endpackage

/* design/five_stage_cpu_instruction_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_stage_cpu_instruction_executor: sequential instruction executor
// Executes one decoded instruction per request beat and returns one
// response beat with the register write, flags, next pc and fault.
// ----------------------------------------------------------------------------
// After reset the block sweeps the data memory to zero, one word per cycle,
// so req_ready first rises once the sweep has written the last word.
// Each instruction then runs through a small sequencer around one shared
// adder: three register file reads (one read port, registered), execute,
// and a write-back step that loads the response register; the next request
// is then taken in the idle state. A load adds a step for the registered
// data memory read, and a divide by a nonzero value adds the steps of the
// one-bit-per-cycle restoring divider and a final sign correction step.
// A new request is taken only when the sequencer is idle; a response may
// still wait in the output register while the next instruction executes.
// Register indexes at or above REG_COUNT read as zero and are not written.
module five_stage_cpu_instruction_executor #(
   parameter int unsigned REG_COUNT  = fsce_pkg::REG_COUNT_DEF,
   parameter int unsigned DATA_WORDS = fsce_pkg::DATA_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_mode,
   input  logic [3:0]  req_dest_reg,
   input  logic [3:0]  req_src_a_reg,
   input  logic [3:0]  req_src_b_reg,
   input  logic [3:0]  req_src_c_reg,
   input  logic signed [31:0] req_immediate,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_enable,
   output logic [3:0]  rsp_write_reg,
   output logic signed [31:0] rsp_write_value,
   output logic        rsp_zero_flag_out,
   output logic        rsp_branch_taken,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_halted,
   output logic        rsp_fault
);

   localparam int unsigned RIDX_W = $clog2(REG_COUNT);
   localparam int unsigned AW     = $clog2(DATA_WORDS);
   localparam int unsigned DW     = fsce_pkg::DATA_W;

   typedef enum logic [9:0] {
      ST_CLR  = 10'b00_0000_0001,
      ST_IDLE = 10'b00_0000_0010,
      ST_RDA  = 10'b00_0000_0100,
      ST_RDB  = 10'b00_0000_1000,
      ST_RDC  = 10'b00_0001_0000,
      ST_EXE  = 10'b00_0010_0000,
      ST_DIV  = 10'b00_0100_0000,
      ST_DVF  = 10'b00_1000_0000,
      ST_LDW  = 10'b01_0000_0000,
      ST_FIN  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // architectural state
   logic [DW-1:0]     pc_ff;
   logic              zf_ff;
   logic              halt_ff;
   logic [DW-1:0]     rf_mem [REG_COUNT];
   logic [REG_COUNT-1:0] rf_vld_ff;
   logic [DW-1:0]     dm_mem [DATA_WORDS];

   // captured request
   logic [4:0]        op_ff;
   logic [3:0]        rd_ff, ra_ff, rb_ff, rc_ff;
   logic [DW-1:0]     imm_ff;

   // operands and read ports
   logic [DW-1:0]     a_ff, b_ff;
   logic [DW-1:0]     rf_q_ff;
   logic              rf_ok_ff;
   logic [3:0]        rf_sel;
   logic [DW-1:0]     rf_rd;
   logic [DW-1:0]     dm_q_ff;
   logic [AW-1:0]     dm_idx;
   logic              dm_we;
   logic [DW-1:0]     dm_wd;
   logic [AW-1:0]     clr_ff;

   // result staging
   logic              res_we_ff, res_setz_ff, res_zf_ff, res_taken_ff;
   logic              res_halt_ff, res_fault_ff;
   logic [DW-1:0]     res_val_ff, res_pc_ff;

   // divider
   logic [DW-1:0]     dv_rem_ff, dv_quo_ff, dv_den_ff;
   logic              dv_neg_ff;
   logic [4:0]        dv_cnt_ff;
   logic [DW:0]       dv_sh, dv_diff;

   // response register
   logic              rsp_valid_ff, rsp_we_ff, rsp_zf_ff, rsp_taken_ff;
   logic              rsp_halt_ff, rsp_fault_ff;
   logic [3:0]        rsp_reg_ff;
   logic [DW-1:0]     rsp_val_ff, rsp_pc_ff;

   // execute datapath
   logic [DW-1:0]     c_val, add_x, add_y, sum;
   logic              add_sub, addr_ok, is_alu;
   logic [DW-1:0]     mul_lo;
   logic              fin_fire, wb_we, zf_new;

   assign req_ready = (state_ff == ST_IDLE);

   // register file read select by sequencer step
   always_comb begin
      case (state_ff)
         ST_RDA:  rf_sel = ra_ff;
         ST_RDB:  rf_sel = rb_ff;
         default: rf_sel = rc_ff;
      endcase
   end

   assign rf_rd = rf_ok_ff ? rf_q_ff : '0;
   assign c_val = rf_rd;

   // shared adder: register ops, immediates and memory addresses
   always_comb begin
      add_x   = a_ff;
      add_y   = b_ff;
      add_sub = 1'b0;
      case (op_ff)
         fsce_pkg::OP_SUB:   add_sub = 1'b1;
         fsce_pkg::OP_ADDL:  add_y = imm_ff;
         fsce_pkg::OP_SUBL: begin
            add_y   = imm_ff;
            add_sub = 1'b1;
         end
         fsce_pkg::OP_LOAD:  add_y = imm_ff;
         fsce_pkg::OP_STORE: begin
            add_x = b_ff;
            add_y = imm_ff;
         end
         default: ;
      endcase
   end

   assign sum     = add_x + (add_y ^ {DW{add_sub}}) + DW'(add_sub);
   assign addr_ok = (sum < DW'(DATA_WORDS));
   assign mul_lo  = a_ff * b_ff;
   assign is_alu  = op_ff inside {fsce_pkg::OP_ADD, fsce_pkg::OP_SUB, fsce_pkg::OP_AND,
                                  fsce_pkg::OP_OR, fsce_pkg::OP_XOR, fsce_pkg::OP_ADDL,
                                  fsce_pkg::OP_SUBL};

   // divider step: shift in one dividend bit, subtract if it fits
   assign dv_sh   = {dv_rem_ff, dv_quo_ff[DW-1]};
   assign dv_diff = dv_sh - {1'b0, dv_den_ff};

   // data memory port: clear sweep or store
   always_comb begin
      dm_we  = 1'b0;
      dm_idx = sum[AW-1:0];
      dm_wd  = (op_ff == fsce_pkg::OP_STORE) ? a_ff : c_val;
      if (state_ff == ST_CLR) begin
         dm_we  = 1'b1;
         dm_idx = clr_ff;
         dm_wd  = '0;
      end else if (state_ff == ST_EXE && !halt_ff && addr_ok &&
                   (op_ff == fsce_pkg::OP_STORE || op_ff == fsce_pkg::OP_STR)) begin
         dm_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[dm_idx] <= dm_wd;
      end
      dm_q_ff <= dm_mem[dm_idx];
   end

   // write-back
   assign fin_fire = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign wb_we    = res_we_ff && (32'(rd_ff) < REG_COUNT);
   assign zf_new   = res_setz_ff ? (res_val_ff == '0) : res_zf_ff;

   always_ff @(posedge clock) begin
      if (fin_fire && wb_we) begin
         rf_mem[RIDX_W'(rd_ff)] <= res_val_ff;
      end
      rf_q_ff  <= rf_mem[RIDX_W'(rf_sel)];
      rf_ok_ff <= (32'(rf_sel) < REG_COUNT) && rf_vld_ff[RIDX_W'(rf_sel)];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR:  if (clr_ff == AW'(DATA_WORDS - 1)) state_in = ST_IDLE;
         ST_IDLE: if (req_valid) state_in = ST_RDA;
         ST_RDA:  state_in = ST_RDB;
         ST_RDB:  state_in = ST_RDC;
         ST_RDC:  state_in = ST_EXE;
         ST_EXE: begin
            state_in = ST_FIN;
            if (!halt_ff) begin
               if (op_ff == fsce_pkg::OP_DIV && b_ff != '0) state_in = ST_DIV;
               if (op_ff == fsce_pkg::OP_LOAD || op_ff == fsce_pkg::OP_LDR) begin
                  state_in = ST_LDW;
               end
            end
         end
         ST_DIV:  if (dv_cnt_ff == 5'd31) state_in = ST_DVF;
         ST_DVF:  state_in = ST_FIN;
         ST_LDW:  state_in = ST_FIN;
         ST_FIN:  if (fin_fire) state_in = ST_IDLE;
         default: state_in = ST_CLR;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         pc_ff        <= fsce_pkg::RESET_PC;
         zf_ff        <= 1'b0;
         halt_ff      <= 1'b0;
         rf_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (fin_fire) begin
            pc_ff        <= res_pc_ff;
            zf_ff        <= zf_new;
            halt_ff      <= res_halt_ff;
            rsp_valid_ff <= 1'b1;
            if (wb_we) begin
               rf_vld_ff[RIDX_W'(rd_ff)] <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            op_ff  <= req_mode;
            rd_ff  <= req_dest_reg;
            ra_ff  <= req_src_a_reg;
            rb_ff  <= req_src_b_reg;
            rc_ff  <= req_src_c_reg;
            imm_ff <= req_immediate;
         end
         ST_RDB:  a_ff <= rf_rd;
         ST_RDC:  b_ff <= rf_rd;
         ST_EXE: begin
            res_we_ff    <= 1'b0;
            res_setz_ff  <= 1'b0;
            res_zf_ff    <= zf_ff;
            res_taken_ff <= 1'b0;
            res_halt_ff  <= halt_ff;
            res_fault_ff <= 1'b0;
            res_val_ff   <= '0;
            res_pc_ff    <= pc_ff + fsce_pkg::PC_STEP;
            dv_rem_ff    <= '0;
            dv_quo_ff    <= a_ff[DW-1] ? (~a_ff + 1'b1) : a_ff;
            dv_den_ff    <= b_ff[DW-1] ? (~b_ff + 1'b1) : b_ff;
            dv_neg_ff    <= a_ff[DW-1] ^ b_ff[DW-1];
            dv_cnt_ff    <= '0;
            if (halt_ff) begin
               res_pc_ff <= pc_ff;
            end else if (is_alu) begin
               res_we_ff   <= 1'b1;
               res_setz_ff <= 1'b1;
               case (op_ff)
                  fsce_pkg::OP_AND: res_val_ff <= a_ff & b_ff;
                  fsce_pkg::OP_OR:  res_val_ff <= a_ff | b_ff;
                  fsce_pkg::OP_XOR: res_val_ff <= a_ff ^ b_ff;
                  default:          res_val_ff <= sum;
               endcase
            end else begin
               case (op_ff)
                  fsce_pkg::OP_MUL: begin
                     res_we_ff   <= 1'b1;
                     res_setz_ff <= 1'b1;
                     res_val_ff  <= mul_lo;
                  end
                  fsce_pkg::OP_DIV: begin
                     res_we_ff    <= 1'b1;
                     res_setz_ff  <= 1'b1;
                     res_fault_ff <= (b_ff == '0);
                  end
                  fsce_pkg::OP_MOVC: begin
                     res_we_ff   <= 1'b1;
                     res_setz_ff <= 1'b1;
                     res_val_ff  <= imm_ff;
                  end
                  fsce_pkg::OP_LOAD, fsce_pkg::OP_LDR: begin
                     res_we_ff    <= 1'b1;
                     res_fault_ff <= !addr_ok;
                  end
                  fsce_pkg::OP_STORE, fsce_pkg::OP_STR: res_fault_ff <= !addr_ok;
                  fsce_pkg::OP_CMP: res_zf_ff <= (a_ff == b_ff);
                  fsce_pkg::OP_BZ, fsce_pkg::OP_BNZ: begin
                     if ((op_ff == fsce_pkg::OP_BZ) == zf_ff) begin
                        res_taken_ff <= 1'b1;
                        res_pc_ff    <= pc_ff + imm_ff;
                     end
                  end
                  fsce_pkg::OP_HALT: res_halt_ff <= 1'b1;
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            dv_cnt_ff <= dv_cnt_ff + 1'b1;
            if (!dv_diff[DW]) begin
               dv_rem_ff <= dv_diff[DW-1:0];
               dv_quo_ff <= {dv_quo_ff[DW-2:0], 1'b1};
            end else begin
               dv_rem_ff <= dv_sh[DW-1:0];
               dv_quo_ff <= {dv_quo_ff[DW-2:0], 1'b0};
            end
         end
         ST_DVF:  res_val_ff <= dv_neg_ff ? (~dv_quo_ff + 1'b1) : dv_quo_ff;
         ST_LDW:  res_val_ff <= res_fault_ff ? '0 : dm_q_ff;
         ST_FIN: begin
            if (fin_fire) begin
               rsp_we_ff    <= wb_we;
               rsp_reg_ff   <= wb_we ? rd_ff : '0;
               rsp_val_ff   <= wb_we ? res_val_ff : '0;
               rsp_zf_ff    <= zf_new;
               rsp_taken_ff <= res_taken_ff;
               rsp_pc_ff    <= res_pc_ff;
               rsp_halt_ff  <= res_halt_ff;
               rsp_fault_ff <= res_fault_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_enable  = rsp_we_ff;
   assign rsp_write_reg     = rsp_reg_ff;
   assign rsp_write_value   = rsp_val_ff;
   assign rsp_zero_flag_out = rsp_zf_ff;
   assign rsp_branch_taken  = rsp_taken_ff;
   assign rsp_next_pc       = rsp_pc_ff;
   assign rsp_halted        = rsp_halt_ff;
   assign rsp_fault         = rsp_fault_ff;

endmodule

/* design/fsce_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsce_checker: port-level checks for the instruction executor
// Watches the request and response ports and flags illegal sequences.
// ----------------------------------------------------------------------------
module fsce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_write_enable,
   input logic [3:0]  rsp_write_reg,
   input logic [31:0] rsp_write_value,
   input logic        rsp_branch_taken,
   input logic [31:0] rsp_next_pc,
   input logic        rsp_halted,
   input logic        rsp_fault
);

   logic halt_seen_ff;

   // remember a delivered halted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         halt_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_halted) begin
         halt_seen_ff <= 1'b1;
      end
   end

   // block is busy right after taking an instruction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // halt mark is sticky
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halt_seen_ff |-> rsp_halted)
      else $error("halted dropped after halt");

   // no write reports zero index and value
   a_no_write_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_reg == 4'd0 && rsp_write_value == 32'd0)
      else $error("stale write fields without write");

   // taken branches neither write nor fault
   a_branch_pure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_taken |-> !rsp_write_enable && !rsp_fault)
      else $error("taken branch with write or fault");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("response changed while stalled");

endmodule

bind five_stage_cpu_instruction_executor fsce_checker u_fsce_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_write_enable (rsp_write_enable),
   .rsp_write_reg    (rsp_write_reg),
   .rsp_write_value  (rsp_write_value),
   .rsp_branch_taken (rsp_branch_taken),
   .rsp_next_pc      (rsp_next_pc),
   .rsp_halted       (rsp_halted),
   .rsp_fault        (rsp_fault)
);

/* dv/five_stage_cpu_instruction_executor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_stage_cpu_instruction_executor_tb: self-checking bench for the executor
// Drives decoded instructions through the request channel and checks every
// response beat against an instruction-level model of the core. A short
// table of directed rows comes first, then random programs, then a halt.
// ----------------------------------------------------------------------------
module five_stage_cpu_instruction_executor_tb;

   localparam int unsigned NUM_RANDOM  = 1820;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned DRAIN_WAIT  = 60;
   localparam int unsigned NUM_REGS    = fsce_pkg::REG_COUNT_DEF;
   localparam int unsigned NUM_WORDS   = fsce_pkg::DATA_WORDS_DEF;
   localparam int unsigned MEM_AW      = $clog2(NUM_WORDS);

   typedef struct packed {
      logic [4:0]  mode;
      logic [3:0]  dest;
      logic [3:0]  src_a;
      logic [3:0]  src_b;
      logic [3:0]  src_c;
      logic [31:0] imm;
   } instr_type;

   typedef struct packed {
      logic        we;
      logic [3:0]  wreg;
      logic [31:0] wval;
      logic        zf;
      logic        taken;
      logic [31:0] npc;
      logic        halted;
      logic        fault;
   } retire_type;

   typedef struct packed {
      instr_type  ins;
      logic       fixed;
      retire_type res;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_mode = '0;
   logic [3:0]  req_dest_reg = '0;
   logic [3:0]  req_src_a_reg = '0;
   logic [3:0]  req_src_b_reg = '0;
   logic [3:0]  req_src_c_reg = '0;
   logic signed [31:0] req_immediate = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_write_enable;
   logic [3:0]  rsp_write_reg;
   logic signed [31:0] rsp_write_value;
   logic        rsp_zero_flag_out;
   logic        rsp_branch_taken;
   logic [31:0] rsp_next_pc;
   logic        rsp_halted;
   logic        rsp_fault;

   five_stage_cpu_instruction_executor dut (.*);

   // model state of the core
   logic [31:0] arch_regs [NUM_REGS];
   logic [31:0] arch_mem  [NUM_WORDS];
   logic [31:0] arch_pc;
   logic        arch_zf;
   logic        arch_halt;

   retire_type  retire_q [$];
   row_type     dir_tab  [$];
   int unsigned mismatches = 0;
   int unsigned rsp_beats  = 0;
   int unsigned cycles     = 0;
   bit          failed     = 1'b0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // execute one instruction on the model state
   function automatic retire_type execute(instr_type i);
      retire_type  r;
      logic [31:0] a, b, c, val, addr;
      logic        wr, setz;
      a = arch_regs[i.src_a];
      b = arch_regs[i.src_b];
      c = arch_regs[i.src_c];
      r = '0;
      val = '0;
      wr = 1'b0;
      setz = 1'b0;
      r.npc = arch_pc + fsce_pkg::PC_STEP;
      if (arch_halt) begin
         r.zf = arch_zf;
         r.npc = arch_pc;
         r.halted = 1'b1;
         return r;
      end
      case (i.mode)
         fsce_pkg::OP_ADD:  begin val = a + b; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_SUB:  begin val = a - b; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_MUL:  begin val = a * b; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_DIV:  begin
            if (b == 32'd0) r.fault = 1'b1;
            else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) val = a;
            else val = $signed(a) / $signed(b);
            wr = 1'b1; setz = 1'b1;
         end
         fsce_pkg::OP_AND:  begin val = a & b; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_OR:   begin val = a | b; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_XOR:  begin val = a ^ b; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_ADDL: begin val = a + i.imm; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_SUBL: begin val = a - i.imm; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_MOVC: begin val = i.imm; wr = 1'b1; setz = 1'b1; end
         fsce_pkg::OP_LOAD, fsce_pkg::OP_LDR: begin
            addr = (i.mode == fsce_pkg::OP_LOAD) ? a + i.imm : a + b;
            if (addr < NUM_WORDS) val = arch_mem[addr[MEM_AW-1:0]];
            else r.fault = 1'b1;
            wr = 1'b1;
         end
         fsce_pkg::OP_STORE, fsce_pkg::OP_STR: begin
            addr = (i.mode == fsce_pkg::OP_STORE) ? b + i.imm : a + b;
            if (addr < NUM_WORDS)
               arch_mem[addr[MEM_AW-1:0]] = (i.mode == fsce_pkg::OP_STORE) ? a : c;
            else r.fault = 1'b1;
         end
         fsce_pkg::OP_CMP:  arch_zf = (a == b);
         fsce_pkg::OP_BZ, fsce_pkg::OP_BNZ: begin
            if ((i.mode == fsce_pkg::OP_BZ) == arch_zf) begin
               r.npc = arch_pc + i.imm;
               r.taken = 1'b1;
            end
         end
         fsce_pkg::OP_HALT: arch_halt = 1'b1;
         default: ;
      endcase
      if (setz) arch_zf = (val == 32'd0);
      if (wr) begin
         arch_regs[i.dest] = val;
         r.we = 1'b1;
         r.wreg = i.dest;
         r.wval = val;
      end
      arch_pc = r.npc;
      r.zf = arch_zf;
      r.halted = arch_halt;
      return r;
   endfunction

   function automatic instr_type ins(logic [4:0] m, logic [3:0] d, logic [3:0] a,
                                     logic [3:0] b, logic [3:0] c, logic [31:0] imm);
      instr_type i;
      i.mode = m; i.dest = d; i.src_a = a; i.src_b = b; i.src_c = c; i.imm = imm;
      return i;
   endfunction

   function automatic retire_type ret(logic [3:0] wreg, logic [31:0] wval, logic zf,
                                      logic [31:0] npc, logic fault);
      retire_type r;
      r = '0;
      r.we = 1'b1; r.wreg = wreg; r.wval = wval; r.zf = zf; r.npc = npc;
      r.fault = fault;
      return r;
   endfunction

   // random instruction: mostly well-formed programs around base regs 0..3
   function automatic instr_type rand_instr();
      instr_type   i;
      int unsigned pick;
      i = ins(5'($urandom_range(0, 18)), 4'($urandom_range(4, 15)),
              4'($urandom), 4'($urandom), 4'($urandom), $urandom);
      pick = $urandom_range(0, 99);
      if (i.mode == fsce_pkg::OP_HALT) i.mode = fsce_pkg::OP_NOP;
      if (pick < 5) i.mode = 5'($urandom_range(19, 31));
      if ($urandom_range(0, 19) == 0) i.dest = 4'($urandom_range(0, 3));
      if (pick >= 5 && pick < 25) begin
         // seed a base register with a small address
         i.mode = fsce_pkg::OP_MOVC;
         i.dest = 4'($urandom_range(0, 3));
         i.imm  = $urandom_range(0, 2047);
      end
      if (i.mode inside {fsce_pkg::OP_LOAD, fsce_pkg::OP_LDR, fsce_pkg::OP_STORE,
                         fsce_pkg::OP_STR} && pick < 90) begin
         i.src_a = 4'($urandom_range(0, 3));
         i.src_b = 4'($urandom_range(0, 3));
         i.imm = $urandom_range(0, 63);
      end
      if (i.mode == fsce_pkg::OP_DIV && pick < 60) i.src_b = 4'($urandom_range(4, 15));
      if ($urandom_range(0, 9) == 0)
         i.imm = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return i;
   endfunction

   // one request beat, with a random gap before it
   task automatic send(instr_type i, logic fixed, retire_type res);
      int unsigned gap;
      retire_type  p;
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode      = i.mode;
      req_dest_reg  = i.dest;
      req_src_a_reg = i.src_a;
      req_src_b_reg = i.src_b;
      req_src_c_reg = i.src_c;
      req_immediate = i.imm;
      req_valid     = 1'b1;
      do @(posedge clock); while (!req_ready);
      p = execute(i);
      retire_q.push_back(fixed ? res : p);
      @(negedge clock);
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      int unsigned n;
      bit          held;
      held = 1'b0;
      @(negedge clock);
      forever begin
         n = $urandom_range(0, 9);
         if (!held && rsp_beats >= 300) begin
            n = 400;
            held = 1'b1;
         end
         if (n > 0) begin
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // response check
   always @(posedge clock) begin
      retire_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats <= rsp_beats + 1;
         got = {rsp_write_enable, rsp_write_reg, rsp_write_value, rsp_zero_flag_out,
                rsp_branch_taken, rsp_next_pc, rsp_halted, rsp_fault};
         if (retire_q.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", got);
         end else begin
            want = retire_q.pop_front();
            if (got !== want) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp we=%b reg=%0d val=%h z=%b br=%b pc=%h h=%b f=%b",
                           want.we, want.wreg, want.wval, want.zf, want.taken,
                           want.npc, want.halted, want.fault,
                           "\n          got we=%b reg=%0d val=%h z=%b br=%b pc=%h h=%b f=%b",
                           got.we, got.wreg, got.wval, got.zf, got.taken,
                           got.npc, got.halted, got.fault);
            end
         end
      end
   end

   // main sequence
   initial begin
      int unsigned wait_cyc;
      foreach (arch_regs[k]) arch_regs[k] = '0;
      foreach (arch_mem[k]) arch_mem[k] = '0;
      arch_pc = fsce_pkg::RESET_PC;
      arch_zf = 1'b0;
      arch_halt = 1'b0;

      // directed rows; fixed expectations only where obvious
      dir_tab.push_back({ins(fsce_pkg::OP_ADD, 4'd1, 4'd0, 4'd0, 4'd0, 32'd0), 1'b1,
                         ret(4'd1, 32'd0, 1'b1, 32'd4004, 1'b0)});
      dir_tab.push_back({ins(fsce_pkg::OP_MOVC, 4'd2, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF), 1'b1,
                         ret(4'd2, 32'h7FFF_FFFF, 1'b0, 32'd4008, 1'b0)});
      dir_tab.push_back({ins(fsce_pkg::OP_MOVC, 4'd3, 4'd0, 4'd0, 4'd0, 32'h8000_0000), 1'b1,
                         ret(4'd3, 32'h8000_0000, 1'b0, 32'd4012, 1'b0)});
      dir_tab.push_back({ins(fsce_pkg::OP_MOVC, 4'd4, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF), 1'b1,
                         ret(4'd4, 32'hFFFF_FFFF, 1'b0, 32'd4016, 1'b0)});
      // divide overflow, then divide by zero
      dir_tab.push_back({ins(fsce_pkg::OP_DIV, 4'd5, 4'd3, 4'd4, 4'd0, 32'd0), 1'b1,
                         ret(4'd5, 32'h8000_0000, 1'b0, 32'd4020, 1'b0)});
      dir_tab.push_back({ins(fsce_pkg::OP_DIV, 4'd6, 4'd2, 4'd0, 4'd0, 32'd0), 1'b1,
                         ret(4'd6, 32'd0, 1'b1, 32'd4024, 1'b1)});
      dir_tab.push_back({ins(fsce_pkg::OP_ADD, 4'd7, 4'd2, 4'd2, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_SUB, 4'd7, 4'd3, 4'd2, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_MUL, 4'd7, 4'd3, 4'd4, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_AND, 4'd7, 4'd2, 4'd3, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_OR, 4'd7, 4'd2, 4'd3, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_XOR, 4'd7, 4'd4, 4'd4, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_ADDL, 4'd15, 4'd2, 4'd0, 4'd0, 32'd1), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_SUBL, 4'd15, 4'd3, 4'd0, 4'd0, 32'd1), 1'b0,
                         retire_type'(0)});
      // memory at the top word, then one past it
      dir_tab.push_back({ins(fsce_pkg::OP_MOVC, 4'd8, 4'd0, 4'd0, 4'd0, 32'd4095), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_STORE, 4'd0, 4'd2, 4'd8, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_LOAD, 4'd9, 4'd8, 4'd0, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_STR, 4'd0, 4'd8, 4'd0, 4'd3, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_LDR, 4'd10, 4'd8, 4'd0, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_LOAD, 4'd11, 4'd8, 4'd0, 4'd0, 32'd1), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_STORE, 4'd0, 4'd2, 4'd4, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      // flag and branches
      dir_tab.push_back({ins(fsce_pkg::OP_CMP, 4'd0, 4'd2, 4'd2, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_BZ, 4'd0, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFF8), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_BNZ, 4'd0, 4'd0, 4'd0, 4'd0, 32'd64), 1'b0,
                         retire_type'(0)});
      dir_tab.push_back({ins(fsce_pkg::OP_NOP, 4'd0, 4'd0, 4'd0, 4'd0, 32'd0), 1'b0,
                         retire_type'(0)});
      // unknown mode acts as a no-op
      dir_tab.push_back({ins(5'd31, 4'd12, 4'd3, 4'd4, 4'd5, 32'hFFFF_FFFF), 1'b0,
                         retire_type'(0)});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[k]) send(dir_tab[k].ins, dir_tab[k].fixed, dir_tab[k].res);
      repeat (NUM_RANDOM) send(rand_instr(), 1'b0, retire_type'(0));
      // halt, then items that must be ignored
      send(ins(fsce_pkg::OP_HALT, 4'd0, 4'd0, 4'd0, 4'd0, 32'd0), 1'b0, retire_type'(0));
      repeat (3) send(rand_instr(), 1'b0, retire_type'(0));
      req_valid = 1'b0;

      wait_cyc = 0;
      while (retire_q.size() != 0 && wait_cyc < 100000) begin
         @(posedge clock);
         wait_cyc++;
      end
      if (retire_q.size() != 0) failed = 1'b1;
      repeat (DRAIN_WAIT) @(posedge clock);

      if (!failed && mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
design/fsce_pkg.sv
design/five_stage_cpu_instruction_executor.sv
design/fsce_checker.sv
dv/five_stage_cpu_instruction_executor_tb.sv
